FILE: hdl/ferp_pkg.sv
// ============================================================================
// ferp_pkg
// Shared widths, opcodes, sizes and controller/datapath link types for the
// flash erase range planner.
// ============================================================================
package ferp_pkg;

   // Field widths of the request and response transactions.
   localparam int ADDR_W = 18;
   localparam int LEN_W  = 19;
   localparam int OP_W   = 8;

   // Default width of the internal cursor; the address space wraps at 2^ADDR_BITS.
   localparam int ADDR_BITS_DEFAULT = 18;

   // SPI NOR erase opcodes.
   localparam logic [OP_W-1:0] OP_ERASE_4K  = 8'h20;
   localparam logic [OP_W-1:0] OP_ERASE_32K = 8'h52;
   localparam logic [OP_W-1:0] OP_ERASE_64K = 8'hD8;

   // Erase granule sizes in bytes.
   localparam logic [LEN_W-1:0] GRAN_4K  = LEN_W'(4 * 1024);
   localparam logic [LEN_W-1:0] GRAN_32K = LEN_W'(32 * 1024);
   localparam logic [LEN_W-1:0] GRAN_64K = LEN_W'(64 * 1024);

   // Cap on the number of commands issued for one request.
   localparam int MAX_CMDS = 30;
   localparam int CNT_W    = $clog2(MAX_CMDS);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // Capture a new request into the cursor registers.
      logic issue;  // Produce one erase command into the response register.
   } ferp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;    // Response register is empty or being taken now.
      logic issue_last;  // The command that would issue now ends the run.
      logic len_zero;    // The offered request has a zero length.
   } ferp_stat_type;

endpackage

FILE: hdl/ferp_stream_if.sv
// ============================================================================
// ferp_req_if / ferp_rsp_if
// Valid/ready channels carrying erase requests and erase commands.
// ============================================================================
interface ferp_req_if;
   import ferp_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] start_address;
   logic [LEN_W-1:0]  erase_length;

   modport source (output valid, output start_address, output erase_length, input ready);
   modport sink   (input valid, input start_address, input erase_length, output ready);
endinterface

interface ferp_rsp_if;
   import ferp_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   erase_opcode;
   logic [ADDR_W-1:0] erase_address;
   logic              last_command;

   modport source (output valid, output erase_opcode, output erase_address,
                   output last_command, input ready);
   modport sink   (input valid, input erase_opcode, input erase_address,
                   input last_command, output ready);
endinterface

FILE: hdl/ferp_datapath.sv
// ============================================================================
// ferp_datapath
// Cursor, remaining length and command count registers, erase size selection
// and the registered response stage.
// ============================================================================
module ferp_datapath #(
   parameter int ADDR_BITS = ferp_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ferp_pkg::ferp_cmd_type       cmd,
   output ferp_pkg::ferp_stat_type      stat,
   input  logic [ferp_pkg::ADDR_W-1:0]  start_address,
   input  logic [ferp_pkg::LEN_W-1:0]   erase_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ferp_pkg::OP_W-1:0]    erase_opcode,
   output logic [ferp_pkg::ADDR_W-1:0]  erase_address,
   output logic                         last_command
);
   import ferp_pkg::*;

   logic [ADDR_BITS-1:0] cursor_ff, cursor_in;
   logic [LEN_W-1:0]     remain_ff, remain_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 valid_ff, valid_in;
   logic [OP_W-1:0]      opcode_ff, opcode_in;
   logic [ADDR_W-1:0]    address_ff, address_in;
   logic                 last_ff, last_in;

   logic                 sel_64k;
   logic                 sel_32k;
   logic [OP_W-1:0]      op_sel;
   logic [LEN_W-1:0]     step_sel;
   logic [LEN_W-1:0]     remain_next;
   logic                 last_now;

   // Pick the largest erase whose alignment and remaining length allow it.
   always_comb begin
      sel_64k = (cursor_ff[15:0] == 16'd0) && (remain_ff >= GRAN_64K);
      sel_32k = (cursor_ff[14:0] == 15'd0) && (remain_ff >= GRAN_32K);
      if (sel_64k) begin
         op_sel   = OP_ERASE_64K;
         step_sel = GRAN_64K;
      end else if (sel_32k) begin
         op_sel   = OP_ERASE_32K;
         step_sel = GRAN_32K;
      end else begin
         op_sel   = OP_ERASE_4K;
         step_sel = GRAN_4K;
      end
      // A trailing partial piece still takes a whole erase.
      remain_next = (remain_ff <= step_sel) ? '0 : remain_ff - step_sel;
      last_now    = (remain_next == '0) || (count_ff == CNT_W'(MAX_CMDS - 1));
   end

   // Next values of the run registers and the response stage.
   always_comb begin
      cursor_in  = cursor_ff;
      remain_in  = remain_ff;
      count_in   = count_ff;
      opcode_in  = opcode_ff;
      address_in = address_ff;
      last_in    = last_ff;
      valid_in   = valid_ff && !rsp_ready;
      if (cmd.load) begin
         cursor_in = ADDR_BITS'(start_address);
         remain_in = erase_length;
         count_in  = '0;
      end
      if (cmd.issue) begin
         cursor_in  = cursor_ff + ADDR_BITS'(step_sel);
         remain_in  = remain_next;
         count_in   = count_ff + CNT_W'(1);
         opcode_in  = op_sel;
         address_in = ADDR_W'(cursor_ff);
         last_in    = last_now;
         valid_in   = 1'b1;
      end
   end

   // Response valid is control state; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         cursor_ff <= '0;
         remain_ff <= '0;
         count_ff  <= '0;
      end else begin
         valid_ff  <= valid_in;
         cursor_ff <= cursor_in;
         remain_ff <= remain_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff  <= opcode_in;
      address_ff <= address_in;
      last_ff    <= last_in;
   end

   // Status toward the controller.
   always_comb begin
      stat.out_free   = !valid_ff || rsp_ready;
      stat.issue_last = last_now;
      stat.len_zero   = (erase_length == '0);
   end

   assign rsp_valid     = valid_ff;
   assign erase_opcode  = opcode_ff;
   assign erase_address = address_ff;
   assign last_command  = last_ff;

endmodule

FILE: hdl/ferp_control.sv
// ============================================================================
// ferp_control
// Run controller: accepts a request when idle, then issues one erase command
// per free response slot until the last command of the run.
// ============================================================================
module ferp_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ferp_pkg::ferp_stat_type stat,
   output ferp_pkg::ferp_cmd_type  cmd
);
   import ferp_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;

   // Command decode and next state.
   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.issue = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // A zero-length request produces nothing and leaves us idle.
               if (!stat.len_zero) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (stat.out_free) begin
               cmd.issue = 1'b1;
               if (stat.issue_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/flash_erase_range_planner_top.sv
// ============================================================================
// flash_erase_range_planner_top
// Splits an erase request into a run of SPI NOR 4K/32K/64K erase commands.
// ============================================================================
// Usage:
//   req_channel carries one transaction per request: start_address and
//   erase_length in bytes. rsp_channel carries one transaction per erase
//   command: erase_opcode, erase_address and last_command, which is set on
//   the final command of the request.
//   A request is taken only while no run is in progress; it is first
//   captured into the cursor registers, then, once the response register is
//   free, the first command is loaded into it, and one command follows per
//   cycle while the receiver keeps ready high. A request splits into N
//   commands, made by the single shared size selector; N is at most 30, and
//   a run that would need more ends at the thirtieth command with
//   last_command set. A zero-length request is accepted and produces no
//   commands.
//   When the receiver stalls, the pending command is held in the response
//   register and the run pauses. The next request may be accepted while the
//   last command of the previous run still waits.
//   Reset (synchronous, active high) returns the block to idle and empties
//   the response register.
// ============================================================================
module flash_erase_range_planner_top #(
   parameter int ADDR_BITS = ferp_pkg::ADDR_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ferp_req_if.sink   req_channel,
   ferp_rsp_if.source rsp_channel
);
   import ferp_pkg::*;

   ferp_cmd_type  cmd;
   ferp_stat_type stat;

   // Sequencing of the run.
   ferp_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Cursor arithmetic and response register.
   ferp_datapath #(
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .start_address (req_channel.start_address),
      .erase_length  (req_channel.erase_length),
      .rsp_valid     (rsp_channel.valid),
      .rsp_ready     (rsp_channel.ready),
      .erase_opcode  (rsp_channel.erase_opcode),
      .erase_address (rsp_channel.erase_address),
      .last_command  (rsp_channel.last_command)
   );

endmodule
